// ===== sv/grd_pkg.sv =====
// Shared constants, types and helpers of the Gaussian resolution density block.
`timescale 1ns / 1ps
`default_nettype none
package grd_pkg;

	// Widths of the fixed-point steps
	localparam int unsigned ROOT_W     = 24;           // floor sqrt of a 48-bit radicand
	localparam int unsigned RAD_W      = 2 * ROOT_W;   // summed energy shifted up by 16
	localparam int unsigned REM_W      = ROOT_W + 2;
	localparam int unsigned SCALE_W    = 24;
	localparam int unsigned AMP_BITS   = 47;           // quotient bits of the amplitude
	localparam int unsigned Q_BITS     = 31;           // quotient bits of d/sigma, Q3.28
	localparam int unsigned Q_FRAC     = 28;
	localparam int unsigned Q_PRE      = Q_BITS - Q_FRAC;
	localparam int unsigned EXP_TERMS  = 10;
	localparam int unsigned SQUARINGS  = 4;
	localparam int unsigned RECIP_SHIFT = 36;

	// Stage map of the cell row
	localparam int unsigned STG_IN       = 1;
	localparam int unsigned STG_SQRT_END = STG_IN + ROOT_W;
	localparam int unsigned STG_MUL      = STG_SQRT_END + 1;
	localparam int unsigned STG_SIG      = STG_MUL + 1;
	localparam int unsigned STG_META     = STG_SIG + 1;
	localparam int unsigned STG_DIV_END  = STG_META + AMP_BITS;
	localparam int unsigned STG_T        = STG_DIV_END + 1;
	localparam int unsigned STG_EXP_END  = STG_T + 2 * EXP_TERMS;
	localparam int unsigned STG_SQ_END   = STG_EXP_END + SQUARINGS;
	localparam int unsigned STG_PROD     = STG_SQ_END + 1;
	localparam int unsigned STG_OUT      = STG_PROD + 1;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_AXIS = 2'd1,
		STATUS_FAR  = 2'd2,
		STATUS_ZERO = 2'd3
	} status_t;

	localparam logic [1:0] AXIS_X       = 2'd0;
	localparam logic [1:0] AXIS_Y       = 2'd1;
	localparam logic       CMD_LIMITS   = 1'b0;
	localparam logic       CMD_DENSITY  = 1'b1;
	localparam logic [1:0] REG_X_SCALE  = 2'd0;
	localparam logic [1:0] REG_Y_SCALE  = 2'd1;

	localparam logic [SCALE_W-1:0]  SCALE_RESET = 24'd32768;
	localparam logic [AMP_BITS-1:0] AMP_NUM     = {31'd1713444047, 16'h0000}; // 1/sqrt(2pi) << 16
	localparam logic [32:0]         Q32_ONE     = 33'h1_0000_0000;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] lower;
		logic [31:0] upper;
		logic        dens_en;
	} grd_meta_t;

	// ceil(2^36 / n): floor(p * m >> 36) == floor(p / n) for p <= 2^31, n <= 10
	function automatic logic [36:0] recip(input logic [3:0] n);
		logic [36:0] m;
		case (n)
			4'd1:    m = 37'd68719476736;
			4'd2:    m = 37'd34359738368;
			4'd3:    m = 37'd22906492246;
			4'd4:    m = 37'd17179869184;
			4'd5:    m = 37'd13743895348;
			4'd6:    m = 37'd11453246123;
			4'd7:    m = 37'd9817068106;
			4'd8:    m = 37'd8589934592;
			4'd9:    m = 37'd7635497416;
			4'd10:   m = 37'd6871947674;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [34:0] v);
		logic [31:0] r;
		if (v > 35'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (v < -35'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/grd_if.sv =====
// Channel interfaces: request, result and register write.
`timescale 1ns / 1ps
`default_nettype none
interface grd_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [1:0]         axis;
	logic signed [31:0] sample_value;
	logic [31:0]        summed_energy;
	logic signed [31:0] mean_value;
	modport source (output valid, command, axis, sample_value, summed_energy, mean_value,
		input ready);
	modport sink (input valid, command, axis, sample_value, summed_energy, mean_value,
		output ready);
endinterface

interface grd_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] lower_limit;
	logic signed [31:0] upper_limit;
	logic [31:0]        density;
	modport source (output valid, status, lower_limit, upper_limit, density, input ready);
	modport sink (input valid, status, lower_limit, upper_limit, density, output ready);
endinterface

interface grd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/gaussian_resolution_density.sv =====
// Throughput: one request per cycle; the whole row of cells advances together and holds
//   when the result register is full and not taken.
// The row is made of 24 root digits, 47 divider bits, 10 Horner terms of two
//   stages, 4 squarings and the arithmetic stages around them.
// Reset clears all stage valids; both axis scales load 0.5 (Q8.16).
`timescale 1ns / 1ps
`default_nettype none
module gaussian_resolution_density (
	input  logic       clk,
	input  logic       arst_n,
	grd_in_if.sink     req,
	grd_out_if.source  rsp,
	grd_cfg_if.sink    cfg
);
	localparam int unsigned LAT = grd_pkg::STG_OUT;

	typedef struct packed {
		logic                         cmd;
		logic                         unk;
		logic [grd_pkg::SCALE_W-1:0]  scale;
		logic [31:0]                  val;
		logic [32:0]                  diff;
	} front_t;

	// configuration
	logic [grd_pkg::SCALE_W-1:0] x_scale_q;
	logic [grd_pkg::SCALE_W-1:0] y_scale_q;

	// row control: one global advance
	logic [LAT:1] vld_q;
	logic         en;

	// front end and square root
	front_t                       front_q [grd_pkg::STG_IN:grd_pkg::STG_SQRT_END];
	logic [31:0]                  energy_s1;
	logic [grd_pkg::REM_W-1:0]    rem_w   [0:grd_pkg::ROOT_W];
	logic [grd_pkg::ROOT_W-1:0]   root_w  [0:grd_pkg::ROOT_W];
	logic [grd_pkg::RAD_W-1:0]    rad_w   [0:grd_pkg::ROOT_W];

	// sigma stages
	logic [32:0] diff_neg;
	logic [47:0] prod_s26;
	logic [31:0] d_s26;
	logic        cmd_s26, unk_s26;
	logic [31:0] val_s26;
	logic [31:0] sigma_w;
	logic [31:0] sigma_s27;
	logic [33:0] three_s27;
	logic        far_s27, zero_s27, cmd_s27, unk_s27;
	logic [31:0] val_s27, d_s27;
	logic signed [34:0] val_ext, three_ext, lo_w, hi_w;
	grd_pkg::grd_meta_t meta_w;
	logic [31:0] d_s28;

	// divider row
	grd_pkg::grd_meta_t meta_q [grd_pkg::STG_META:grd_pkg::STG_OUT];
	logic [31:0] sig_q [grd_pkg::STG_META:grd_pkg::STG_DIV_END-1];
	logic [grd_pkg::Q_PRE-1:0] dsh_q [grd_pkg::STG_META:grd_pkg::STG_META+grd_pkg::Q_PRE-1];
	logic [31:0]                   qrem_w [0:grd_pkg::Q_BITS];
	logic [grd_pkg::AMP_BITS-1:0]  qquo_w [0:grd_pkg::Q_BITS];
	logic [31:0]                   arem_w [0:grd_pkg::AMP_BITS];
	logic [grd_pkg::AMP_BITS-1:0]  aquo_w [0:grd_pkg::AMP_BITS];
	logic [grd_pkg::Q_BITS-1:0] qhold_q
		[grd_pkg::STG_META+grd_pkg::Q_BITS+1:grd_pkg::STG_DIV_END];
	logic [grd_pkg::AMP_BITS-1:0] amp_q [grd_pkg::STG_DIV_END+1:grd_pkg::STG_SQ_END];

	// exponential and output
	logic [2*grd_pkg::Q_BITS-1:0] qsq_w;
	logic [31:0] t_s76;
	logic [31:0] s_w  [0:grd_pkg::EXP_TERMS];
	logic [32:0] r_w  [0:grd_pkg::EXP_TERMS];
	logic [32:0] sq_w [0:grd_pkg::SQUARINGS];
	logic [63:0] phi_s101;
	logic [48:0] plo_s101;
	logic [63:0] dsum_w;
	logic [31:0] dens_s102;

	// ---------------------------------------------------------------------------------
	// Register writes: always accepted; indexes past the y scale are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q <= grd_pkg::SCALE_RESET;
			y_scale_q <= grd_pkg::SCALE_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == grd_pkg::REG_X_SCALE)
				x_scale_q <= cfg.data;
			else if (cfg.index == grd_pkg::REG_Y_SCALE)
				y_scale_q <= cfg.data;
		end
	end

	// ---------------------------------------------------------------------------------
	// Row control. Every stage moves when the result register is free or being taken.
	assign en        = !vld_q[LAT] || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-1:grd_pkg::STG_IN], req.valid};
	end

	// ---------------------------------------------------------------------------------
	// Stage 1: pick the axis scale, flag an unknown axis, form value minus mean.
	always_ff @(posedge clk) begin
		if (en) begin
			front_q[grd_pkg::STG_IN].cmd   <= req.command;
			front_q[grd_pkg::STG_IN].unk   <= !(req.axis == grd_pkg::AXIS_X
				|| req.axis == grd_pkg::AXIS_Y);
			front_q[grd_pkg::STG_IN].scale <= (req.axis == grd_pkg::AXIS_Y)
				? y_scale_q : x_scale_q;
			front_q[grd_pkg::STG_IN].val   <= req.sample_value;
			front_q[grd_pkg::STG_IN].diff  <= {req.sample_value[31], req.sample_value}
				- {req.mean_value[31], req.mean_value};
			energy_s1 <= req.summed_energy;
			for (int k = grd_pkg::STG_IN + 1; k <= grd_pkg::STG_SQRT_END; k++)
				front_q[k] <= front_q[k-1];
		end
	end

	// Square root of energy << 16, one root bit per cell.
	assign rem_w[0]  = '0;
	assign root_w[0] = '0;
	assign rad_w[0]  = {energy_s1, 16'h0000};

	for (genvar k = 0; k < grd_pkg::ROOT_W; k++) begin : g_sqrt
		grd_sqrt_cell u_cell (
			.clk     (clk),
			.en      (en),
			.rem_in  (rem_w[k]),
			.root_in (root_w[k]),
			.rad_in  (rad_w[k]),
			.rem_q   (rem_w[k+1]),
			.root_q  (root_w[k+1]),
			.rad_q   (rad_w[k+1])
		);
	end

	// ---------------------------------------------------------------------------------
	// Stage 26: scale times root; |value - mean|.
	assign diff_neg = ~front_q[grd_pkg::STG_SQRT_END].diff + 33'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s26 <= front_q[grd_pkg::STG_SQRT_END].scale * root_w[grd_pkg::ROOT_W];
			d_s26    <= front_q[grd_pkg::STG_SQRT_END].diff[32]
				? diff_neg[31:0] : front_q[grd_pkg::STG_SQRT_END].diff[31:0];
			cmd_s26  <= front_q[grd_pkg::STG_SQRT_END].cmd;
			unk_s26  <= front_q[grd_pkg::STG_SQRT_END].unk;
			val_s26  <= front_q[grd_pkg::STG_SQRT_END].val;
		end
	end

	// Stage 27: sigma, three sigma, the zero and four sigma tests.
	assign sigma_w = prod_s26[47:16];

	always_ff @(posedge clk) begin
		if (en) begin
			sigma_s27 <= sigma_w;
			three_s27 <= {2'b00, sigma_w} + {1'b0, sigma_w, 1'b0};
			far_s27   <= {2'b00, d_s26} > {sigma_w, 2'b00};
			zero_s27  <= sigma_w == '0;
			cmd_s27   <= cmd_s26;
			unk_s27   <= unk_s26;
			val_s27   <= val_s26;
			d_s27     <= d_s26;
		end
	end

	// Stage 28: saturated limits and the status that travels with the item.
	assign val_ext   = {{3{val_s27[31]}}, val_s27};
	assign three_ext = {1'b0, three_s27};
	assign lo_w      = val_ext - three_ext;
	assign hi_w      = val_ext + three_ext;

	always_comb begin
		meta_w = '0;
		if (unk_s27) begin
			meta_w.status = grd_pkg::STATUS_AXIS;
		end else if (cmd_s27 == grd_pkg::CMD_LIMITS) begin
			meta_w.status = grd_pkg::STATUS_OK;
			meta_w.lower  = grd_pkg::sat32(lo_w);
			meta_w.upper  = grd_pkg::sat32(hi_w);
		end else if (zero_s27) begin
			meta_w.status = grd_pkg::STATUS_ZERO;
		end else if (far_s27) begin
			meta_w.status = grd_pkg::STATUS_FAR;
		end else begin
			meta_w.status  = grd_pkg::STATUS_OK;
			meta_w.dens_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_q[grd_pkg::STG_META] <= meta_w;
			for (int k = grd_pkg::STG_META + 1; k <= grd_pkg::STG_OUT; k++)
				meta_q[k] <= meta_q[k-1];
			sig_q[grd_pkg::STG_META] <= sigma_s27;
			for (int k = grd_pkg::STG_META + 1; k < grd_pkg::STG_DIV_END; k++)
				sig_q[k] <= sig_q[k-1];
			d_s28 <= d_s27;
			dsh_q[grd_pkg::STG_META] <= d_s27[grd_pkg::Q_PRE-1:0];
			for (int k = grd_pkg::STG_META + 1; k < grd_pkg::STG_META + grd_pkg::Q_PRE; k++)
				dsh_q[k] <= {dsh_q[k-1][grd_pkg::Q_PRE-2:0], 1'b0};
		end
	end

	// ---------------------------------------------------------------------------------
	// Two dividers share the row: (d << 28) / sigma and (1/sqrt(2pi) << 16) / sigma.
	assign qrem_w[0] = {{grd_pkg::Q_PRE{1'b0}}, d_s28[31:grd_pkg::Q_PRE]};
	assign qquo_w[0] = '0;
	assign arem_w[0] = '0;
	assign aquo_w[0] = '0;

	for (genvar j = 0; j < grd_pkg::Q_BITS; j++) begin : g_qdiv
		logic qbit;
		if (j < grd_pkg::Q_PRE) begin : g_dbit
			assign qbit = dsh_q[grd_pkg::STG_META+j][grd_pkg::Q_PRE-1];
		end else begin : g_zbit
			assign qbit = 1'b0;
		end
		grd_div_cell u_cell (
			.clk     (clk),
			.en      (en),
			.rem_in  (qrem_w[j]),
			.bit_in  (qbit),
			.divisor (sig_q[grd_pkg::STG_META+j]),
			.quo_in  (qquo_w[j]),
			.rem_q   (qrem_w[j+1]),
			.quo_q   (qquo_w[j+1])
		);
	end

	for (genvar j = 0; j < grd_pkg::AMP_BITS; j++) begin : g_adiv
		grd_div_cell u_cell (
			.clk     (clk),
			.en      (en),
			.rem_in  (arem_w[j]),
			.bit_in  (grd_pkg::AMP_NUM[grd_pkg::AMP_BITS-1-j]),
			.divisor (sig_q[grd_pkg::STG_META+j]),
			.quo_in  (aquo_w[j]),
			.rem_q   (arem_w[j+1]),
			.quo_q   (aquo_w[j+1])
		);
	end

	// q finishes early and waits for the amplitude divider.
	always_ff @(posedge clk) begin
		if (en) begin
			qhold_q[grd_pkg::STG_META+grd_pkg::Q_BITS+1] <=
				qquo_w[grd_pkg::Q_BITS][grd_pkg::Q_BITS-1:0];
			for (int k = grd_pkg::STG_META + grd_pkg::Q_BITS + 2;
					k <= grd_pkg::STG_DIV_END; k++)
				qhold_q[k] <= qhold_q[k-1];
			amp_q[grd_pkg::STG_DIV_END+1] <= aquo_w[grd_pkg::AMP_BITS];
			for (int k = grd_pkg::STG_DIV_END + 2; k <= grd_pkg::STG_SQ_END; k++)
				amp_q[k] <= amp_q[k-1];
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 76: t = q^2 / 2, Q.28.
	assign qsq_w = qhold_q[grd_pkg::STG_DIV_END] * qhold_q[grd_pkg::STG_DIV_END];

	always_ff @(posedge clk) begin
		if (en)
			t_s76 <= qsq_w[60:29];
	end

	// exp(-t/16) by Horner, highest term first, then squared four times.
	assign s_w[0] = t_s76;
	assign r_w[0] = grd_pkg::Q32_ONE;

	for (genvar i = 0; i < grd_pkg::EXP_TERMS; i++) begin : g_exp
		grd_exp_cell u_cell (
			.clk  (clk),
			.en   (en),
			.term (4'(grd_pkg::EXP_TERMS - i)),
			.s_in (s_w[i]),
			.r_in (r_w[i]),
			.s_q  (s_w[i+1]),
			.r_q  (r_w[i+1])
		);
	end

	assign sq_w[0] = r_w[grd_pkg::EXP_TERMS];

	for (genvar i = 0; i < grd_pkg::SQUARINGS; i++) begin : g_square
		grd_square_cell u_cell (
			.clk  (clk),
			.en   (en),
			.r_in (sq_w[i]),
			.r_q  (sq_w[i+1])
		);
	end

	// ---------------------------------------------------------------------------------
	// Amplitude times exponential, split at bit 16 of the amplitude, then saturate; zero unless density is enabled.
	assign dsum_w = phi_s101 + {31'h0, plo_s101[48:16]};

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s101  <= amp_q[grd_pkg::STG_SQ_END][grd_pkg::AMP_BITS-1:16]
				* sq_w[grd_pkg::SQUARINGS];
			plo_s101  <= amp_q[grd_pkg::STG_SQ_END][15:0] * sq_w[grd_pkg::SQUARINGS];
			if (!meta_q[grd_pkg::STG_PROD].dens_en)
				dens_s102 <= '0;
			else if (dsum_w[63:48] != '0)
				dens_s102 <= 32'hFFFF_FFFF;
			else
				dens_s102 <= dsum_w[47:16];
		end
	end

	// Result register
	assign rsp.valid       = vld_q[LAT];
	assign rsp.status      = meta_q[grd_pkg::STG_OUT].status;
	assign rsp.lower_limit = meta_q[grd_pkg::STG_OUT].lower;
	assign rsp.upper_limit = meta_q[grd_pkg::STG_OUT].upper;
	assign rsp.density     = dens_s102;

	// ---------------------------------------------------------------------------------
	a_axis_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == grd_pkg::STATUS_AXIS
		|-> rsp.lower_limit == '0 && rsp.upper_limit == '0 && rsp.density == '0)
		else $error("unknown axis result carries data");

	a_dens_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.density != '0 |-> rsp.status == grd_pkg::STATUS_OK)
		else $error("density on an error result");

	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[grd_pkg::STG_SQ_END] |-> sq_w[grd_pkg::SQUARINGS] <= grd_pkg::Q32_ONE)
		else $error("exponential above one");

endmodule
`default_nettype wire

// ===== sv/grd_sqrt_cell.sv =====
// One digit of the square root: two radicand bits in, one root bit out.
`timescale 1ns / 1ps
`default_nettype none
module grd_sqrt_cell (
	input  logic                      clk,
	input  logic                      en,
	input  logic [grd_pkg::REM_W-1:0]  rem_in,
	input  logic [grd_pkg::ROOT_W-1:0] root_in,
	input  logic [grd_pkg::RAD_W-1:0]  rad_in,
	output logic [grd_pkg::REM_W-1:0]  rem_q,
	output logic [grd_pkg::ROOT_W-1:0] root_q,
	output logic [grd_pkg::RAD_W-1:0]  rad_q
);
	logic [grd_pkg::REM_W+1:0] acc;
	logic [grd_pkg::REM_W+1:0] trial;
	logic                      take;

	assign acc   = {rem_in, rad_in[grd_pkg::RAD_W-1 -: 2]};
	assign trial = {2'b00, root_in, 2'b01};
	assign take  = acc >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? grd_pkg::REM_W'(acc - trial) : acc[grd_pkg::REM_W-1:0];
			root_q <= {root_in[grd_pkg::ROOT_W-2:0], take};
			rad_q  <= {rad_in[grd_pkg::RAD_W-3:0], 2'b00};
		end
	end
endmodule
`default_nettype wire

// ===== sv/grd_div_cell.sv =====
// One restoring division step: one dividend bit in, one quotient bit out.
`timescale 1ns / 1ps
`default_nettype none
module grd_div_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [31:0]                 rem_in,
	input  logic                        bit_in,
	input  logic [31:0]                 divisor,
	input  logic [grd_pkg::AMP_BITS-1:0] quo_in,
	output logic [31:0]                 rem_q,
	output logic [grd_pkg::AMP_BITS-1:0] quo_q
);
	logic [32:0] acc;
	logic        take;

	assign acc  = {rem_in, bit_in};
	assign take = acc >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= take ? 32'(acc - {1'b0, divisor}) : acc[31:0];
			quo_q <= {quo_in[grd_pkg::AMP_BITS-2:0], take};
		end
	end
endmodule
`default_nettype wire

// ===== sv/grd_exp_cell.sv =====
// One Horner term of exp(-s): r' = 1 - (s*r)/n, Q0.32, two stages.
`timescale 1ns / 1ps
`default_nettype none
module grd_exp_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [3:0]  term,
	input  logic [31:0] s_in,
	input  logic [32:0] r_in,
	output logic [31:0] s_q,
	output logic [32:0] r_q
);
	logic [64:0] prod;
	logic [68:0] scaled;
	logic [31:0] p_s1;
	logic [31:0] s_s1;

	assign prod   = s_in * r_in;
	assign scaled = p_s1 * grd_pkg::recip(term);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= prod[63:32];
			s_s1 <= s_in;
			r_q  <= grd_pkg::Q32_ONE
				- {1'b0, scaled[grd_pkg::RECIP_SHIFT+31:grd_pkg::RECIP_SHIFT]};
			s_q  <= s_s1;
		end
	end
endmodule
`default_nettype wire

// ===== sv/grd_square_cell.sv =====
// One squaring of the exponential, Q0.32; exactly one is left as is.
`timescale 1ns / 1ps
`default_nettype none
module grd_square_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [32:0] r_in,
	output logic [32:0] r_q
);
	logic [63:0] sq;

	assign sq = r_in[31:0] * r_in[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= r_in[32] ? r_in : {1'b0, sq[63:32]};
		end
	end
endmodule
`default_nettype wire
